@@ src/obb_separating_axis_test_macros.svh @@
// Assertion macros shared by the separating axis test RTL.
// Needs no other file; synthesis builds see empty bodies.
`ifndef OBB_SEPARATING_AXIS_TEST_MACROS_SVH
`define OBB_SEPARATING_AXIS_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("obb assertion failed");
`define OBB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("obb assertion failed");
`else
`define OBB_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define OBB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ src/obb_pkg.sv @@
// Shared types and constants for the separating axis test.
// No dependencies.
`default_nettype none
package obb_pkg;
    localparam int DIGIT_W   = 16;
    localparam int FACE_AXES = 6;
    localparam int LAST_AXIS = 14;

    localparam logic OP_CORNER = 1'b0;
    localparam logic OP_NORMAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX_RD0,
        ST_AX_RD1,
        ST_AX_RD2,
        ST_CROSS,
        ST_CWAIT,
        ST_ZCHK,
        ST_CRD,
        ST_CLOAD,
        ST_DOT,
        ST_DWAIT,
        ST_EVAL1,
        ST_EVAL2
    } back_state_t;

    typedef struct packed {
        logic       wr_corner;
        logic       wr_normal;
        logic       box;
        logic [2:0] slot;
        logic       run;
    } cmd_ctl_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic top;
        logic last;
    } mac_ctl_t;
endpackage
`default_nettype wire

@@ src/obb_front.sv @@
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on obb_pkg.
`default_nettype none
module obb_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire                          op,
    input  wire                          box,
    input  wire  [2:0]                   slot,
    input  wire  signed [31:0]           x_value,
    input  wire  signed [31:0]           y_value,
    input  wire  signed [31:0]           z_value,
    input  wire                          run,
    output logic                         q_valid,
    output obb_pkg::cmd_ctl_t            q_ctl,
    output logic signed [COORD_WIDTH-1:0] q_x,
    output logic signed [COORD_WIDTH-1:0] q_y,
    output logic signed [COORD_WIDTH-1:0] q_z,
    input  wire                          q_pop
);
    logic signed [COORD_WIDTH-1:0] cx, cy, cz;
    obb_pkg::cmd_ctl_t             ctl;
    obb_pkg::cmd_ctl_t             ctl_mem [2];
    logic [3*COORD_WIDTH-1:0]      vec_mem [2];
    logic                          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                    count_reg;
    logic                          push;

    generate
        if (COORD_WIDTH <= 32) begin : g_trunc
            assign cx = x_value[COORD_WIDTH-1:0];
            assign cy = y_value[COORD_WIDTH-1:0];
            assign cz = z_value[COORD_WIDTH-1:0];
        end else begin : g_ext
            assign cx = COORD_WIDTH'(x_value);
            assign cy = COORD_WIDTH'(y_value);
            assign cz = COORD_WIDTH'(z_value);
        end
    endgenerate

    always_comb
    begin
        ctl.wr_corner = (op == obb_pkg::OP_CORNER);
        ctl.wr_normal = (op == obb_pkg::OP_NORMAL) && (slot < 3'd3);
        ctl.box       = box;
        ctl.slot      = slot;
        ctl.run       = run;
    end

    assign req_stall = (count_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign q_ctl     = ctl_mem[rd_ptr_reg];
    assign q_x       = vec_mem[rd_ptr_reg][0*COORD_WIDTH +: COORD_WIDTH];
    assign q_y       = vec_mem[rd_ptr_reg][1*COORD_WIDTH +: COORD_WIDTH];
    assign q_z       = vec_mem[rd_ptr_reg][2*COORD_WIDTH +: COORD_WIDTH];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= ctl;
            vec_mem[wr_ptr_reg] <= {cz, cy, cx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

@@ src/obb_mac.sv @@
// Shared multiply-accumulate unit: one signed operand times one 16-bit digit
// per cycle, Horner accumulation over digits. Depends on obb_pkg.
`default_nettype none
module obb_mac #(
    parameter int COORD_WIDTH = 32,
    parameter int ACC_WIDTH   = 84
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  obb_pkg::mac_ctl_t               ctl,
    input  wire  signed [COORD_WIDTH-1:0]   a,
    input  wire  signed [obb_pkg::DIGIT_W:0] d,
    output logic signed [ACC_WIDTH-1:0]     acc,
    output logic                            done
);
    localparam int PW = COORD_WIDTH + obb_pkg::DIGIT_W + 1;

    logic signed [PW-1:0]        prod_reg;
    obb_pkg::mac_ctl_t           ctl_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] base;
    logic                        done_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * d;
    end

    // Start a digit from zero on the top digit, else shift the partial sum up.
    assign base = ctl_reg.top ? '0 : (acc_reg <<< obb_pkg::DIGIT_W);

    always_ff @(posedge clk)
    begin
        if (ctl_reg.valid)
        begin
            if (ctl_reg.first)
                acc_reg <= base + ACC_WIDTH'(prod_reg);
            else
                acc_reg <= acc_reg + ACC_WIDTH'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid && ctl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

@@ src/obb_back.sv @@
// Back end: vector stores, axis sequencer, projection span check, result register.
// Depends on obb_pkg, obb_mac and the assertion macro header.
`default_nettype none
`include "obb_separating_axis_test_macros.svh"
module obb_back #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           q_valid,
    input  obb_pkg::cmd_ctl_t             q_ctl,
    input  wire  signed [COORD_WIDTH-1:0] q_x,
    input  wire  signed [COORD_WIDTH-1:0] q_y,
    input  wire  signed [COORD_WIDTH-1:0] q_z,
    output logic                          q_pop,
    output logic                          res_valid,
    input  wire                           res_stall,
    output logic                          collide
);
    localparam int CW    = COORD_WIDTH;
    localparam int AW    = 2 * CW + 1 - FRAC_BITS;
    localparam int BW    = (AW > CW + 1) ? AW : CW + 1;
    localparam int ND    = (BW + obb_pkg::DIGIT_W - 1) / obb_pkg::DIGIT_W;
    localparam int BXW   = ND * obb_pkg::DIGIT_W;
    localparam int DGW   = (ND > 1) ? $clog2(ND) : 1;
    localparam int ACC_W = CW + BW + 2;
    localparam int EW    = ACC_W + 2;
    localparam logic [DGW-1:0] TOP_DIG = DGW'(ND - 1);

    obb_pkg::back_state_t state_reg, state_next;
    logic [3:0]           axis_reg, axis_next;
    logic [1:0]           ci_reg, ci_next, cj_reg, cj_next;
    logic [1:0]           comp_reg, comp_next, term_reg, term_next;
    logic [DGW-1:0]       dig_reg, dig_next;
    logic [3:0]           corner_reg, corner_next;
    logic signed [CW-1:0] u_reg [3];
    logic signed [CW-1:0] u_next [3];
    logic signed [CW-1:0] v_reg [3];
    logic signed [CW-1:0] v_next [3];
    logic signed [CW-1:0] row_reg [3];
    logic signed [CW-1:0] row_next [3];
    logic signed [BW-1:0] axv_reg [3];
    logic signed [BW-1:0] axv_next [3];
    logic signed [ACC_W-1:0] mn_reg [2];
    logic signed [ACC_W-1:0] mn_next [2];
    logic signed [ACC_W-1:0] mx_reg [2];
    logic signed [ACC_W-1:0] mx_next [2];
    logic signed [EW-1:0] hi_reg, hi_next, lo_reg, lo_next;
    logic signed [EW-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic                 out_valid_reg, out_valid_next, collide_reg, collide_next;

    logic [3*CW-1:0] corner_mem [16];
    logic [3*CW-1:0] normal_mem [6];
    logic [3*CW-1:0] crd_reg, nrd_reg;
    logic [3:0]      crd_addr;
    logic [2:0]      nrd_addr, nwr_addr;
    logic            crd_en, nrd_en;

    obb_pkg::mac_ctl_t     mac_ctl;
    logic signed [CW-1:0]  mac_a;
    logic signed [obb_pkg::DIGIT_W:0] mac_d;
    logic signed [ACC_W-1:0] acc;
    logic                  done;

    logic signed [BW-1:0]  b_sel;
    logic signed [BXW-1:0] b_ext;
    logic [obb_pkg::DIGIT_W-1:0] slice;
    logic                  overlap;

    obb_mac #(
        .COORD_WIDTH (CW),
        .ACC_WIDTH   (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .d     (mac_d),
        .acc   (acc),
        .done  (done)
    );

    assign nwr_addr = q_ctl.box ? (q_ctl.slot + 3'd3) : q_ctl.slot;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_ctl.wr_corner)
            corner_mem[{q_ctl.box, q_ctl.slot}] <= {q_z, q_y, q_x};
        if (crd_en)
            crd_reg <= corner_mem[crd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_ctl.wr_normal)
            normal_mem[nwr_addr] <= {q_z, q_y, q_x};
        if (nrd_en)
            nrd_reg <= normal_mem[nrd_addr];
    end

    // Digit of the B operand; lower digits unsigned, top digit carries the sign.
    always_comb
    begin
        if (state_reg == obb_pkg::ST_CROSS)
            b_sel = (term_reg == 2'd0) ? BW'(v_reg[2]) : -(BW'(v_reg[1]));
        else
            b_sel = axv_reg[0];
        b_ext = BXW'(b_sel);
        slice = b_ext[int'(dig_reg) * obb_pkg::DIGIT_W +: obb_pkg::DIGIT_W];
        mac_d = (dig_reg == TOP_DIG) ? {slice[obb_pkg::DIGIT_W-1], slice} : {1'b0, slice};
        if (state_reg == obb_pkg::ST_CROSS)
            mac_a = (term_reg == 2'd0) ? u_reg[1] : u_reg[2];
        else
            mac_a = row_reg[0];
    end

    assign overlap = (hi_reg - lo_reg) < (s0_reg + s1_reg);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        comp_next      = comp_reg;
        term_next      = term_reg;
        dig_next       = dig_reg;
        corner_next    = corner_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        row_next       = row_reg;
        axv_next       = axv_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg && res_stall;
        collide_next   = collide_reg;
        q_pop          = 1'b0;
        crd_en         = 1'b0;
        crd_addr       = corner_reg;
        nrd_en         = 1'b0;
        nrd_addr       = (axis_reg < 4'(obb_pkg::FACE_AXES)) ? axis_reg[2:0] : {1'b0, ci_reg};
        mac_ctl        = '0;

        case (state_reg)
            obb_pkg::ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    if (q_ctl.run)
                    begin
                        axis_next  = 4'd0;
                        ci_next    = 2'd0;
                        cj_next    = 2'd0;
                        state_next = obb_pkg::ST_AX_RD0;
                    end
                end
            end
            obb_pkg::ST_AX_RD0:
            begin
                nrd_en     = 1'b1;
                state_next = obb_pkg::ST_AX_RD1;
            end
            obb_pkg::ST_AX_RD1:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    u_next[k]   = nrd_reg[k*CW +: CW];
                    axv_next[k] = BW'(u_next[k]);
                end
                if (axis_reg < 4'(obb_pkg::FACE_AXES))
                    state_next = obb_pkg::ST_ZCHK;
                else
                begin
                    nrd_en     = 1'b1;
                    nrd_addr   = 3'd3 + {1'b0, cj_reg};
                    state_next = obb_pkg::ST_AX_RD2;
                end
            end
            obb_pkg::ST_AX_RD2:
            begin
                for (int k = 0; k < 3; k++)
                    v_next[k] = nrd_reg[k*CW +: CW];
                comp_next  = 2'd0;
                term_next  = 2'd0;
                dig_next   = TOP_DIG;
                state_next = obb_pkg::ST_CROSS;
            end
            obb_pkg::ST_CROSS:
            begin
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (term_reg == 2'd0);
                mac_ctl.top   = (dig_reg == TOP_DIG);
                mac_ctl.last  = (term_reg == 2'd1) && (dig_reg == '0);
                if (term_reg == 2'd0)
                    term_next = 2'd1;
                else
                begin
                    term_next = 2'd0;
                    if (dig_reg == '0)
                        state_next = obb_pkg::ST_CWAIT;
                    else
                        dig_next = dig_reg - 1'b1;
                end
            end
            obb_pkg::ST_CWAIT:
            begin
                if (done)
                begin
                    // Shift the new component in and rotate the normals.
                    axv_next[0] = axv_reg[1];
                    axv_next[1] = axv_reg[2];
                    axv_next[2] = BW'(acc >>> FRAC_BITS);
                    u_next[0] = u_reg[1];
                    u_next[1] = u_reg[2];
                    u_next[2] = u_reg[0];
                    v_next[0] = v_reg[1];
                    v_next[1] = v_reg[2];
                    v_next[2] = v_reg[0];
                    term_next = 2'd0;
                    dig_next  = TOP_DIG;
                    if (comp_reg == 2'd2)
                        state_next = obb_pkg::ST_ZCHK;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = obb_pkg::ST_CROSS;
                    end
                end
            end
            obb_pkg::ST_ZCHK:
            begin
                corner_next = 4'd0;
                state_next  = obb_pkg::ST_CRD;
                if (axv_reg[0] == '0 && axv_reg[1] == '0 && axv_reg[2] == '0)
                begin
                    if (axis_reg == 4'(obb_pkg::LAST_AXIS))
                    begin
                        out_valid_next = 1'b1;
                        collide_next   = 1'b1;
                        state_next     = obb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 4'd1;
                        state_next = obb_pkg::ST_AX_RD0;
                        if (axis_reg >= 4'(obb_pkg::FACE_AXES))
                        begin
                            cj_next = (cj_reg == 2'd2) ? 2'd0 : cj_reg + 2'd1;
                            ci_next = (cj_reg == 2'd2) ? ci_reg + 2'd1 : ci_reg;
                        end
                    end
                end
            end
            obb_pkg::ST_CRD:
            begin
                crd_en     = 1'b1;
                state_next = obb_pkg::ST_CLOAD;
            end
            obb_pkg::ST_CLOAD:
            begin
                for (int k = 0; k < 3; k++)
                    row_next[k] = crd_reg[k*CW +: CW];
                term_next  = 2'd0;
                dig_next   = TOP_DIG;
                state_next = obb_pkg::ST_DOT;
            end
            obb_pkg::ST_DOT:
            begin
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (term_reg == 2'd0);
                mac_ctl.top   = (dig_reg == TOP_DIG);
                mac_ctl.last  = (term_reg == 2'd2) && (dig_reg == '0);
                row_next[0] = row_reg[1];
                row_next[1] = row_reg[2];
                row_next[2] = row_reg[0];
                axv_next[0] = axv_reg[1];
                axv_next[1] = axv_reg[2];
                axv_next[2] = axv_reg[0];
                if (term_reg != 2'd2)
                    term_next = term_reg + 2'd1;
                else
                begin
                    term_next = 2'd0;
                    if (dig_reg == '0)
                        state_next = obb_pkg::ST_DWAIT;
                    else
                        dig_next = dig_reg - 1'b1;
                end
            end
            obb_pkg::ST_DWAIT:
            begin
                if (done)
                begin
                    if (corner_reg[2:0] == 3'd0)
                    begin
                        mn_next[corner_reg[3]] = acc;
                        mx_next[corner_reg[3]] = acc;
                    end
                    else
                    begin
                        if (acc < mn_reg[corner_reg[3]])
                            mn_next[corner_reg[3]] = acc;
                        if (mx_reg[corner_reg[3]] < acc)
                            mx_next[corner_reg[3]] = acc;
                    end
                    corner_next = corner_reg + 4'd1;
                    state_next  = (corner_reg == 4'd15) ? obb_pkg::ST_EVAL1 : obb_pkg::ST_CRD;
                end
            end
            obb_pkg::ST_EVAL1:
            begin
                hi_next    = (mx_reg[0] < mx_reg[1]) ? EW'(mx_reg[1]) : EW'(mx_reg[0]);
                lo_next    = (mn_reg[0] < mn_reg[1]) ? EW'(mn_reg[0]) : EW'(mn_reg[1]);
                s0_next    = EW'(mx_reg[0]) - EW'(mn_reg[0]);
                s1_next    = EW'(mx_reg[1]) - EW'(mn_reg[1]);
                state_next = obb_pkg::ST_EVAL2;
            end
            obb_pkg::ST_EVAL2:
            begin
                if (!overlap)
                begin
                    out_valid_next = 1'b1;
                    collide_next   = 1'b0;
                    state_next     = obb_pkg::ST_IDLE;
                end
                else if (axis_reg == 4'(obb_pkg::LAST_AXIS))
                begin
                    out_valid_next = 1'b1;
                    collide_next   = 1'b1;
                    state_next     = obb_pkg::ST_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + 4'd1;
                    state_next = obb_pkg::ST_AX_RD0;
                    if (axis_reg >= 4'(obb_pkg::FACE_AXES))
                    begin
                        cj_next = (cj_reg == 2'd2) ? 2'd0 : cj_reg + 2'd1;
                        ci_next = (cj_reg == 2'd2) ? ci_reg + 2'd1 : ci_reg;
                    end
                end
            end
            default:
                state_next = obb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg    <= axis_next;
        ci_reg      <= ci_next;
        cj_reg      <= cj_next;
        comp_reg    <= comp_next;
        term_reg    <= term_next;
        dig_reg     <= dig_next;
        corner_reg  <= corner_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        row_reg     <= row_next;
        axv_reg     <= axv_next;
        mn_reg      <= mn_next;
        mx_reg      <= mx_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        collide_reg <= collide_next;
    end

    assign res_valid = out_valid_reg;
    assign collide   = collide_reg;

    `OBB_ASSERT_IMPL(a_done_in_wait, clk, rst_n, done,
        (state_reg == obb_pkg::ST_CWAIT || state_reg == obb_pkg::ST_DWAIT))
    `OBB_ASSERT_IMPL(a_pop_when_idle, clk, rst_n, q_pop,
        (state_reg == obb_pkg::ST_IDLE && !out_valid_reg))
    `OBB_ASSERT_NEXT(a_run_starts, clk, rst_n, (q_pop && q_ctl.run),
        (state_reg == obb_pkg::ST_AX_RD0 && axis_reg == 4'd0))
endmodule
`default_nettype wire

@@ src/obb_separating_axis_test.sv @@
// Top level of the oriented box separating axis test.
// Depends on obb_pkg, obb_front and obb_back.
//
// Request channel (req_valid / req_stall): each request loads one corner or
// face normal of box 0 or 1, but a normal slot above 2 is dropped; a request
// with run set starts the overlap test once its vector is stored. A two-entry
// queue takes requests in one cycle each while the test engine is busy;
// req_stall rises only when it is full. Result channel (res_valid / res_stall):
// one collide bit per run request, held in an output register until taken;
// while it waits, queued loads behind it hold (stores are not touched until the
// result leaves). A test walks up to fifteen axes through one shared
// multiplier that takes one 16-bit digit per cycle of a B operand split
// into D digits (D = ceil(max(2*COORD_WIDTH+1-FRAC_BITS, COORD_WIDTH+1)/16),
// 4 by default). A cross-product axis is first formed one component at a time,
// and each axis is then projected from all sixteen corners; a separated pair
// stops at the first separating axis.
// Reset empties the queue and the result register; the vector stores are
// not cleared and must be loaded before a test.
`default_nettype none
module obb_separating_axis_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_stall,
    input  wire               op,
    input  wire               box,
    input  wire  [2:0]        slot,
    input  wire  signed [31:0] x_value,
    input  wire  signed [31:0] y_value,
    input  wire  signed [31:0] z_value,
    input  wire               run,
    output logic              res_valid,
    input  wire               res_stall,
    output logic              collide
);
    // Queue head towards the engine
    logic                          q_valid;
    logic                          q_pop;
    obb_pkg::cmd_ctl_t             q_ctl;
    logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z;

    // Accept, classify and convert requests; hold them in the queue
    obb_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .box       (box),
        .slot      (slot),
        .x_value   (x_value),
        .y_value   (y_value),
        .z_value   (z_value),
        .run       (run),
        .q_valid   (q_valid),
        .q_ctl     (q_ctl),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_pop     (q_pop)
    );

    // Store vectors, walk the axes and drive the result register
    obb_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ctl     (q_ctl),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .collide   (collide)
    );
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for obb_separating_axis_test: loads two boxes, runs the test and
// checks every collide result against a typed value or an in-module predictor.
// Depends on obb_pkg and the RTL under src/.
`default_nettype none
module testbench;
    localparam int ONE         = 65536;     // 1.0 in Q16.16
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 25000000;  // far beyond the slowest correct run
    localparam int HOLD_CYCLES = 6000;      // long receiver hold-off
    localparam int DRAIN_WAIT  = 300;

    // Wide enough for a 32-bit corner times a rescaled cross-product axis,
    // summed over three components, with room to spare.
    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic        op;
        logic        box;
        logic [2:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        run;
        logic        has_exp;   // expected collide typed into the row
        logic        exp;
    } request_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    logic op;
    logic box;
    logic [2:0] slot;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic run;
    logic res_valid;
    logic res_stall;
    logic collide;

    // Typed expectation that travels alongside the request being offered.
    logic row_has_exp;
    logic row_exp;

    // Predictor state: world corners and face normals of both boxes.
    logic signed [31:0] corner_pos[2][8][3];
    logic signed [31:0] normal_dir[2][3][3];

    logic pending_collide[$];
    int   error_count;
    int   cycle_count;
    int   items_sent;
    int   burst_left;
    bit   hold_req;

    request_t stim_rows[$];
    request_t episode_q[$];

    obb_separating_axis_test u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .op       (op),
        .box      (box),
        .slot     (slot),
        .x_value  (x_value),
        .y_value  (y_value),
        .z_value  (z_value),
        .run      (run),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .collide  (collide)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Project every corner of both boxes onto one axis; the axis overlaps
    // when the combined span is strictly shorter than the sum of the spans.
    // An all-zero axis cannot separate anything, so it counts as overlapping.
    function automatic logic axis_spans_overlap(input wide_t a0, input wide_t a1,
                                                input wide_t a2);
        wide_t d;
        wide_t lo_b[2];
        wide_t hi_b[2];
        wide_t hi;
        wide_t lo;
        if (a0 == 0 && a1 == 0 && a2 == 0)
            return 1'b1;
        for (int b = 0; b < 2; b++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                d = wide_t'(corner_pos[b][c][0]) * a0
                  + wide_t'(corner_pos[b][c][1]) * a1
                  + wide_t'(corner_pos[b][c][2]) * a2;
                if (c == 0 || d < lo_b[b])
                    lo_b[b] = d;
                if (c == 0 || d > hi_b[b])
                    hi_b[b] = d;
            end
        end
        hi = (hi_b[0] > hi_b[1]) ? hi_b[0] : hi_b[1];
        lo = (lo_b[0] < lo_b[1]) ? lo_b[0] : lo_b[1];
        return (hi - lo) < ((hi_b[0] - lo_b[0]) + (hi_b[1] - lo_b[1]));
    endfunction

    // Walk the six face normals, then the nine cross products n0[i] x n1[j]
    // rescaled by an arithmetic shift; stop at the first separating axis.
    function automatic logic boxes_collide();
        wide_t ax[3];
        wide_t prod;
        int p;
        int q;
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!axis_spans_overlap(wide_t'(normal_dir[b][i][0]),
                                        wide_t'(normal_dir[b][i][1]),
                                        wide_t'(normal_dir[b][i][2])))
                    return 1'b0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p = (k + 1) % 3;
                    q = (k + 2) % 3;
                    prod = wide_t'(normal_dir[0][i][p]) * wide_t'(normal_dir[1][j][q])
                         - wide_t'(normal_dir[0][i][q]) * wide_t'(normal_dir[1][j][p]);
                    ax[k] = prod >>> 16;
                end
                if (!axis_spans_overlap(ax[0], ax[1], ax[2]))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Store each accepted corner or slot 0-2 normal, then queue the collide
    // result a run request is owed: the typed value where the row carries one.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            if (op == obb_pkg::OP_CORNER)
            begin
                corner_pos[box][slot][0] = x_value;
                corner_pos[box][slot][1] = y_value;
                corner_pos[box][slot][2] = z_value;
            end
            else if (slot < 3)
            begin
                normal_dir[box][slot][0] = x_value;
                normal_dir[box][slot][1] = y_value;
                normal_dir[box][slot][2] = z_value;
            end
            if (run)
                pending_collide.insert(pending_collide.size(),
                                       row_has_exp ? row_exp : boxes_collide());
        end
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_collide.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual collide=%0b",
                         $time, collide);
                error_count++;
            end
            else
            begin
                if (collide !== pending_collide[0])
                begin
                    $display("%0t collide mismatch: expected %0b actual %0b",
                             $time, pending_collide[0], collide);
                    error_count++;
                end
                void'(pending_collide.pop_front());
            end
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in phases of random density, plus one long hold
    // ------------------------------------------------------------------
    initial
    begin
        int phase_left;
        int stall_pct;
        phase_left = 0;
        stall_pct = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // Hold off long enough for the queue to fill and stall requests.
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(5, 80);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                phase_left--;
                res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken; between bursts drop valid
    // for a random gap (often none, so back-to-back stretches occur).
    task automatic send_request(input request_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        req_valid   <= 1'b1;
        op          <= r.op;
        box         <= r.box;
        slot        <= r.slot;
        x_value     <= r.x;
        y_value     <= r.y;
        z_value     <= r.z;
        run         <= r.run;
        row_has_exp <= r.has_exp;
        row_exp     <= r.exp;
        do
            @(posedge clk);
        while (req_stall);
        if (r.run || r.op == obb_pkg::OP_CORNER || r.slot < 3)
            items_sent++;
    endtask

    function automatic request_t make_request(input logic o, input logic b,
                                              input logic [2:0] s, input int x,
                                              input int y, input int z,
                                              input logic r);
        request_t t;
        t.op = o;
        t.box = b;
        t.slot = s;
        t.x = x;
        t.y = y;
        t.z = z;
        t.run = r;
        t.has_exp = 1'b0;
        t.exp = 1'b0;
        return t;
    endfunction

    // Build one box: random centre and half sizes, normals either axis
    // aligned (rotated, random signs) or arbitrary; corners follow from them.
    task automatic build_box(input logic b);
        int centre[3];
        int half[3];
        int nrm[3][3];
        longint acc;
        int rot;
        logic aligned;
        aligned = ($urandom_range(0, 1) == 0);
        rot = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++)
        begin
            centre[a] = $urandom_range(0, 6 * ONE) - 3 * ONE;
            half[a] = $urandom_range(ONE / 4, 2 * ONE);
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (aligned)
                    nrm[k][a] = (a == (k + rot) % 3)
                              ? (($urandom_range(0, 1) == 1) ? ONE : -ONE) : 0;
                else
                    nrm[k][a] = $urandom_range(0, 2 * ONE) - ONE;
            end
            episode_q.insert(episode_q.size(),
                             make_request(obb_pkg::OP_NORMAL, b, 3'(k), nrm[k][0],
                                          nrm[k][1], nrm[k][2], 1'b0));
        end
        for (int c = 0; c < 8; c++)
        begin
            int pos[3];
            for (int a = 0; a < 3; a++)
            begin
                acc = centre[a];
                for (int k = 0; k < 3; k++)
                    acc += (c[k] ? 1 : -1) * ((longint'(half[k]) * nrm[k][a]) >>> 16);
                pos[a] = int'(acc);
            end
            episode_q.insert(episode_q.size(),
                             make_request(obb_pkg::OP_CORNER, b, 3'(c), pos[0], pos[1],
                                          pos[2], 1'b0));
        end
    endtask

    task automatic shuffle_episode();
        request_t t;
        int j;
        for (int i = episode_q.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = episode_q[i];
            episode_q[i] = episode_q[j];
            episode_q[j] = t;
        end
    endtask

    task automatic send_episode();
        while (episode_q.size() > 0)
            send_request(episode_q.pop_front());
    endtask

    initial
    begin
        request_t r;
        int kind;
        int episode;
        int cut;
        rst_n = 1'b0;
        req_valid = 1'b0;
        op = obb_pkg::OP_CORNER;
        box = 1'b0;
        slot = '0;
        x_value = '0;
        y_value = '0;
        z_value = '0;
        run = 1'b0;
        row_has_exp = 1'b0;
        row_exp = 1'b0;
        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: unit cube at the origin and one shifted by half a
        // unit, axis normals; every store is written before the first run.
        for (int b = 0; b < 2; b++)
        begin
            for (int c = 0; c < 8; c++)
                stim_rows.insert(stim_rows.size(),
                                 make_request(obb_pkg::OP_CORNER, b, 3'(c),
                                              c[0] * ONE + b * ONE / 2,
                                              c[1] * ONE + b * ONE / 2,
                                              c[2] * ONE + b * ONE / 2, 1'b0));
            for (int k = 0; k < 3; k++)
                stim_rows.insert(stim_rows.size(),
                                 make_request(obb_pkg::OP_NORMAL, b, 3'(k),
                                              (k == 0) ? ONE : 0, (k == 1) ? ONE : 0,
                                              (k == 2) ? ONE : 0, 1'b0));
        end
        // Overlapping cubes: every axis overlaps, several cross axes are zero.
        stim_rows[$].run = 1'b1;
        stim_rows[$].has_exp = 1'b1;
        stim_rows[$].exp = 1'b1;
        // Normal slot past the third: vector dropped, run still answers.
        r = make_request(obb_pkg::OP_NORMAL, 1'b1, 3'd7, 32'h7fffffff, 32'h80000000,
                         32'hffffffff, 1'b1);
        r.has_exp = 1'b1;
        r.exp = 1'b1;
        stim_rows.insert(stim_rows.size(), r);
        // Extreme coordinates and an extreme normal, run on corner and normal loads.
        stim_rows.insert(stim_rows.size(),
                         make_request(obb_pkg::OP_CORNER, 1'b1, 3'd3, 32'h7fffffff,
                                      32'h80000000, 0, 1'b1));
        stim_rows.insert(stim_rows.size(),
                         make_request(obb_pkg::OP_CORNER, 1'b0, 3'd6, 32'h80000000,
                                      32'h7fffffff, 32'hffffffff, 1'b1));
        stim_rows.insert(stim_rows.size(),
                         make_request(obb_pkg::OP_NORMAL, 1'b0, 3'd2, 32'h7fffffff,
                                      32'h80000000, 32'h7fffffff, 1'b1));
        foreach (stim_rows[i])
            send_request(stim_rows[i]);

        // Random part: mostly whole well-formed box pairs, plus moves of one
        // box, truncated sequences and raw noise.
        items_sent = 0;
        episode = 0;
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                build_box(1'b0);
                build_box(1'b1);
                shuffle_episode();
                episode_q[$].run = 1'b1;
            end
            else if (kind < 75)
            begin
                build_box($urandom_range(0, 1));
                shuffle_episode();
                episode_q[$].run = 1'b1;
            end
            else if (kind < 85)
            begin
                build_box(1'b0);
                build_box(1'b1);
                shuffle_episode();
                cut = $urandom_range(1, episode_q.size() - 1);
                episode_q[cut - 1].run = 1'b1;
                while (episode_q.size() > cut)
                    void'(episode_q.pop_back());
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    episode_q.insert(episode_q.size(),
                                     make_request($urandom_range(0, 1),
                                                  $urandom_range(0, 1),
                                                  $urandom_range(0, 7), $urandom,
                                                  $urandom, $urandom,
                                                  ($urandom_range(0, 7) == 0)));
            end
            send_episode();
            episode++;
            // Hold the receiver off while requests keep coming.
            if (episode == 12)
                hold_req = 1'b1;
            // Pause the sender until every result has come back.
            if (episode == 30)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                burst_left = 0;
                while (pending_collide.size() != 0)
                    @(posedge clk);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_collide.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+src
src/obb_pkg.sv
src/obb_front.sv
src/obb_mac.sv
src/obb_back.sv
src/obb_separating_axis_test.sv
dv/testbench.sv
